// ----- rtl/core/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue cell chain.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH    = 32;
   localparam int HELD_WIDTH    = 5;

   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_POP_EMPTY  = 2'd1,
      STATUS_PUSH_FULL  = 2'd2,
      STATUS_UNUSED     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD       = 3'd0,
      CELL_PUSH_FRONT = 3'd1,
      CELL_PUSH_BACK  = 3'd2,
      CELL_POP_FRONT  = 3'd3,
      CELL_POP_BACK   = 3'd4
   } cell_op_type;

   typedef struct packed {
      mode_type                       mode;
      logic signed [WORD_WIDTH-1:0]   push_value;
   } req_type;

   typedef struct packed {
      status_type                     status;
      logic signed [WORD_WIDTH-1:0]   popped_value;
      logic [HELD_WIDTH-1:0]          items_held;
      logic signed [WORD_WIDTH-1:0]   front_value;
      logic signed [WORD_WIDTH-1:0]   back_value;
   } rsp_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic                           valid;
      logic signed [WORD_WIDTH-1:0]   data;
   } link_type;

endpackage

// ----- rtl/core/deq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue chain: a word and a valid bit, shifted by neighbors.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  deq_pkg::cell_op_type                 op,
   input  logic signed [deq_pkg::WORD_WIDTH-1:0] push_value,
   input  deq_pkg::link_type                    left_link,
   input  deq_pkg::link_type                    right_link,
   output deq_pkg::link_type                    own_link
);

   logic                                 valid_ff;
   logic                                 valid_in;
   logic signed [deq_pkg::WORD_WIDTH-1:0] data_ff;
   logic signed [deq_pkg::WORD_WIDTH-1:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (op)
         deq_pkg::CELL_PUSH_FRONT: begin
            valid_in = left_link.valid;
            data_in  = left_link.data;
         end
         deq_pkg::CELL_PUSH_BACK: begin
            // first empty slot takes the word
            if (!valid_ff && left_link.valid) begin
               valid_in = 1'b1;
               data_in  = push_value;
            end
         end
         deq_pkg::CELL_POP_FRONT: begin
            valid_in = right_link.valid;
            data_in  = right_link.data;
         end
         deq_pkg::CELL_POP_BACK: begin
            if (valid_ff && !right_link.valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            valid_in = valid_ff;
            data_in  = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign own_link.valid = valid_ff;
   assign own_link.data  = data_ff;

endmodule

// ----- rtl/core/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
// the result strobe is registered from the start transfer and rises in the next cycle
// throughput: one operation per cycle; busy stays low, the cell chain settles
//    every operation in a single shift of its neighbors
// reset: synchronous, clears the valid bits of all cells, the count and the
//    result strobe; stored words keep whatever they held
// the receiver cannot stall: each result shows for exactly one cycle
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue built as a chain of cells, front at cell zero.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  deq_pkg::req_type  req_payload,
   output logic              rsp_strobe,
   output deq_pkg::rsp_type  rsp_payload
);

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // links[i+1] is cell i; links[0] and links[DEPTH+1] bound the ends of the chain
   deq_pkg::link_type                    links [DEPTH+2];
   deq_pkg::cell_op_type                 cell_op;

   logic                                 accept;
   logic                                 full;
   logic                                 empty;
   logic signed [deq_pkg::WORD_WIDTH-1:0] back_sel;

   logic [COUNT_WIDTH-1:0]               count_ff;
   logic [COUNT_WIDTH-1:0]               count_in;
   deq_pkg::status_type                  status_ff;
   deq_pkg::status_type                  status_in;
   logic signed [deq_pkg::WORD_WIDTH-1:0] popped_ff;
   logic signed [deq_pkg::WORD_WIDTH-1:0] popped_in;
   logic                                 strobe_ff;

   // the chain never stalls a request
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign full  = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);

   // left end feeds the pushed word in, right end reads as empty
   assign links[0].valid       = 1'b1;
   assign links[0].data        = req_payload.push_value;
   assign links[DEPTH+1].valid = 1'b0;
   assign links[DEPTH+1].data  = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      deq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_op),
         .push_value (req_payload.push_value),
         .left_link  (links[i]),
         .right_link (links[i+2]),
         .own_link   (links[i+1])
      );
   end

   // the last valid cell is the one whose right neighbor is empty
   always_comb begin
      back_sel = '0;
      for (int i = 1; i <= DEPTH; i++) begin
         if (links[i].valid && !links[i+1].valid) begin
            back_sel = back_sel | links[i].data;
         end
      end
   end

   // decode the operation into one chain-wide cell command
   always_comb begin
      cell_op   = deq_pkg::CELL_HOLD;
      status_in = deq_pkg::STATUS_DONE;
      popped_in = '0;
      count_in  = count_ff;
      if (accept) begin
         unique case (req_payload.mode)
            deq_pkg::MODE_PUSH_FRONT: begin
               if (full) begin
                  status_in = deq_pkg::STATUS_PUSH_FULL;
               end else begin
                  cell_op  = deq_pkg::CELL_PUSH_FRONT;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::MODE_PUSH_BACK: begin
               if (full) begin
                  status_in = deq_pkg::STATUS_PUSH_FULL;
               end else begin
                  cell_op  = deq_pkg::CELL_PUSH_BACK;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::MODE_POP_FRONT: begin
               if (empty) begin
                  status_in = deq_pkg::STATUS_POP_EMPTY;
               end else begin
                  cell_op   = deq_pkg::CELL_POP_FRONT;
                  popped_in = links[1].data;
                  count_in  = count_ff - 1'b1;
               end
            end
            deq_pkg::MODE_POP_BACK: begin
               if (empty) begin
                  status_in = deq_pkg::STATUS_POP_EMPTY;
               end else begin
                  cell_op   = deq_pkg::CELL_POP_BACK;
                  popped_in = back_sel;
                  count_in  = count_ff - 1'b1;
               end
            end
            default: begin
               cell_op = deq_pkg::CELL_HOLD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
      // result payload, no reset needed
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   // front and back come straight off the chain after the transfer settled it
   assign rsp_strobe               = strobe_ff;
   assign rsp_payload.status       = status_ff;
   assign rsp_payload.popped_value = popped_ff;
   assign rsp_payload.items_held   = deq_pkg::HELD_WIDTH'(count_ff);
   assign rsp_payload.front_value  = links[1].valid ? links[1].data : '0;
   assign rsp_payload.back_value   = back_sel;

endmodule

// ----- rtl/core/deq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the queue, bound onto the top level.
// ----------------------------------------------------------------------------
module deq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input deq_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input deq_pkg::rsp_type rsp_payload
);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("missing result after start transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result without start transfer");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.items_held == '0) |->
         (rsp_payload.front_value == '0 && rsp_payload.back_value == '0))
      else $error("empty queue shows nonzero ends");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == deq_pkg::STATUS_POP_EMPTY) |->
         (rsp_payload.items_held == '0 && rsp_payload.popped_value == '0))
      else $error("pop on empty with nonzero count or word");

   a_push_echo: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.mode == deq_pkg::MODE_PUSH_BACK) |=>
         (rsp_payload.status == deq_pkg::STATUS_PUSH_FULL ||
          rsp_payload.back_value == $past(req_payload.push_value)))
      else $error("push back word not at back");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

// ----- verif/double_ended_queue_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_test
// Self-checking bench for the double-ended queue: a directed table of
// operations (empty pops, extreme words, fill to full, pushes on full), then
// random operations in push-heavy, pop-heavy and mixed phases so that the
// store keeps running into both full and empty. Every result is compared
// field by field against its typed-in value or a queue-based prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_top_test;

   localparam int QUEUE_DEPTH    = deq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_OPS     = 850;
   localparam int IDLE_PERCENT   = 27;
   // random ops in this window go out back to back, no idle cycles
   localparam int BURST_FIRST    = 300;
   localparam int BURST_LAST     = 449;
   // random op before which the sender waits for every result to drain
   localparam int DRAIN_POINT    = 500;
   localparam int PHASE_LENGTH   = 40;
   localparam int TAIL_CYCLES    = 4;
   localparam int REPORT_LIMIT   = 10;

   // phases of the random part, chosen per block of operations
   typedef enum int {
      PHASE_FILL,
      PHASE_DRAIN,
      PHASE_MIXED
   } phase_type;

   // one row of the directed table: the operation, and a typed-in result
   // where it is obvious, otherwise the prediction is used
   typedef struct {
      deq_pkg::req_type  op;
      bit                typed;
      deq_pkg::rsp_type  want;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   deq_pkg::req_type  req_payload;
   logic              rsp_strobe;
   deq_pkg::rsp_type  rsp_payload;

   // predicted contents of the store, front at index zero
   logic signed [deq_pkg::WORD_WIDTH-1:0] held_words[$];
   // results still to come, oldest first
   deq_pkg::rsp_type  rsp_expected[$];
   stim_row_type      directed_rows[$];
   int                mismatch_count = 0;

   double_ended_queue_top #(
      .DEPTH (QUEUE_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // 10 ns clock, low first so that every edge is a clean rise
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // apply one operation to the predicted store and work out its result
   function automatic deq_pkg::rsp_type predict_operation(deq_pkg::req_type op);
      deq_pkg::rsp_type r;
      r = '0;
      r.status = deq_pkg::STATUS_DONE;
      case (op.mode)
         deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
            // a push on a full store is dropped and leaves everything alone
            if (held_words.size() >= QUEUE_DEPTH) begin
               r.status = deq_pkg::STATUS_PUSH_FULL;
            end else if (op.mode == deq_pkg::MODE_PUSH_FRONT) begin
               held_words.push_front(op.push_value);
            end else begin
               held_words.push_back(op.push_value);
            end
         end
         default: begin
            // a pop on an empty store is ignored, popped word stays zero
            if (held_words.size() == 0) begin
               r.status = deq_pkg::STATUS_POP_EMPTY;
            end else if (op.mode == deq_pkg::MODE_POP_FRONT) begin
               r.popped_value = held_words.pop_front();
            end else begin
               r.popped_value = held_words.pop_back();
            end
         end
      endcase
      r.items_held = deq_pkg::HELD_WIDTH'(held_words.size());
      // first and last words read as zero when nothing is held
      if (held_words.size() != 0) begin
         r.front_value = held_words[0];
         r.back_value  = held_words[$];
      end
      return r;
   endfunction

   function automatic deq_pkg::rsp_type make_rsp(deq_pkg::status_type status,
                                                 logic [deq_pkg::WORD_WIDTH-1:0] popped,
                                                 int held,
                                                 logic [deq_pkg::WORD_WIDTH-1:0] first,
                                                 logic [deq_pkg::WORD_WIDTH-1:0] last);
      deq_pkg::rsp_type r;
      r.status       = status;
      r.popped_value = popped;
      r.items_held   = deq_pkg::HELD_WIDTH'(held);
      r.front_value  = first;
      r.back_value   = last;
      return r;
   endfunction

   function automatic deq_pkg::req_type make_req(deq_pkg::mode_type mode,
                                                 logic [deq_pkg::WORD_WIDTH-1:0] value);
      deq_pkg::req_type r;
      r.mode       = mode;
      r.push_value = value;
      return r;
   endfunction

   function automatic void add_row(deq_pkg::req_type op, bit typed, deq_pkg::rsp_type want);
      stim_row_type row;
      row.op    = op;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // directed table
   function automatic void build_directed_table();
      deq_pkg::rsp_type none;
      none = '0;
      // pops right after reset hit the empty store; push_value must be ignored
      add_row(make_req(deq_pkg::MODE_POP_FRONT, 32'hFFFF_FFFF), 1'b1,
              make_rsp(deq_pkg::STATUS_POP_EMPTY, 32'h0, 0, 32'h0, 32'h0));
      add_row(make_req(deq_pkg::MODE_POP_BACK, 32'h8000_0000), 1'b1,
              make_rsp(deq_pkg::STATUS_POP_EMPTY, 32'h0, 0, 32'h0, 32'h0));
      // extreme words in at both ends and back out again
      add_row(make_req(deq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF), 1'b1,
              make_rsp(deq_pkg::STATUS_DONE, 32'h0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      add_row(make_req(deq_pkg::MODE_PUSH_BACK, 32'h8000_0000), 1'b1,
              make_rsp(deq_pkg::STATUS_DONE, 32'h0, 2, 32'h7FFF_FFFF, 32'h8000_0000));
      add_row(make_req(deq_pkg::MODE_POP_BACK, 32'h0), 1'b1,
              make_rsp(deq_pkg::STATUS_DONE, 32'h8000_0000, 1, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF));
      add_row(make_req(deq_pkg::MODE_POP_FRONT, 32'hFFFF_FFFF), 1'b1,
              make_rsp(deq_pkg::STATUS_DONE, 32'h7FFF_FFFF, 0, 32'h0, 32'h0));
      // fill to full from both ends, alternating front and back pushes
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         add_row(make_req((i % 2 == 0) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK,
                          (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF
                                   : 32'h0101_0101 * i ^ 32'hA5A5_0000),
                 1'b0, none);
      end
      // pushes on full are dropped, then one pop from each end
      add_row(make_req(deq_pkg::MODE_PUSH_FRONT, 32'h1234_5678), 1'b0, none);
      add_row(make_req(deq_pkg::MODE_PUSH_BACK, 32'h8765_4321), 1'b0, none);
      add_row(make_req(deq_pkg::MODE_POP_FRONT, 32'h0), 1'b0, none);
      add_row(make_req(deq_pkg::MODE_POP_BACK, 32'h0), 1'b0, none);
   endfunction

   // random operation, biased by phase so full and empty both come up often
   function automatic deq_pkg::req_type random_operation(phase_type phase);
      deq_pkg::req_type r;
      int roll;
      int push_percent;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_FILL:  push_percent = 75;
         PHASE_DRAIN: push_percent = 25;
         default:     push_percent = 50;
      endcase
      if (roll < push_percent) begin
         r.mode = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT;
      end else begin
         r.mode = $urandom_range(0, 1) ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT;
      end
      // some extreme words, mostly full-range random ones
      case ($urandom_range(0, 11))
         0:       r.push_value = 32'h7FFF_FFFF;
         1:       r.push_value = 32'h8000_0000;
         2:       r.push_value = 32'h0;
         3:       r.push_value = 32'hFFFF_FFFF;
         default: r.push_value = $urandom;
      endcase
      return r;
   endfunction

   // present one operation until it transfers, then record what should come back.
   // busy is sampled at the falling edge, where it is stable until the next rise
   task automatic send_operation(input deq_pkg::req_type op, input bit may_idle,
                                 input bit typed, input deq_pkg::rsp_type want);
      deq_pkg::rsp_type predicted;
      while (may_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= op;
      @(negedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
         @(negedge clock);
      end
      // the transfer happens at this edge
      @(posedge clock);
      predicted = predict_operation(op);
      rsp_expected.push_back(typed ? want : predicted);
   endtask

   // sender stops and waits until every outstanding result has arrived
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (rsp_expected.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // stimulus
   initial begin
      phase_type phase;
      deq_pkg::req_type op;
      deq_pkg::rsp_type none;
      none        = '0;
      phase       = PHASE_MIXED;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      build_directed_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, with idling so gaps land between table rows too
      foreach (directed_rows[i]) begin
         send_operation(directed_rows[i].op, 1'b1, directed_rows[i].typed,
                        directed_rows[i].want);
      end
      wait_for_drain();

      // random part
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % PHASE_LENGTH == 0) begin
            phase = phase_type'($urandom_range(0, 2));
         end
         if (i == DRAIN_POINT) begin
            wait_for_drain();
         end
         op = random_operation(phase);
         send_operation(op, !(i >= BURST_FIRST && i <= BURST_LAST), 1'b0, none);
      end
      start <= 1'b0;

      // let the last results come in, then keep checking for stray results
      @(posedge clock);
      while (rsp_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && rsp_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // result checker: results show for one cycle, sampled mid-cycle
   always @(negedge clock) begin
      deq_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (rsp_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: result with nothing expected: %p", $realtime, rsp_payload);
            end
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_payload.status !== want.status
                || rsp_payload.popped_value !== want.popped_value
                || rsp_payload.items_held !== want.items_held
                || rsp_payload.front_value !== want.front_value
                || rsp_payload.back_value !== want.back_value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch status %0d/%0d popped %h/%h held %0d/%0d",
                           $realtime, want.status, rsp_payload.status,
                           want.popped_value, rsp_payload.popped_value,
                           want.items_held, rsp_payload.items_held);
                  $display("   front %h/%h back %h/%h (expected/actual)",
                           want.front_value, rsp_payload.front_value,
                           want.back_value, rsp_payload.back_value);
               end
            end
         end
      end
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_top.sv
rtl/core/deq_checker.sv
verif/double_ended_queue_top_test.sv
